// File: rtl/core/dqd_pkg.sv
// ----------------------------------------------------------------------------
// dqd_pkg
// shared constants and command codes for the dual quadrature decoder
// ----------------------------------------------------------------------------
package dqd_pkg;

    localparam int COUNT_BITS = 16;
    localparam int OUT_BITS   = 16;
    localparam int PIN_BITS   = 4;
    localparam int CMD_BITS   = 2;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [OUT_BITS-1:0]   out_t;
    typedef logic [PIN_BITS-1:0]   pins_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INIT         = 2'd0,
        CMD_PIN_EVENT    = 2'd1,
        CMD_REPORT_LEFT  = 2'd2,
        CMD_REPORT_RIGHT = 2'd3
    } cmd_t;

    // pin positions inside pin_levels
    localparam int PIN_LEFT_A  = 0;
    localparam int PIN_LEFT_B  = 1;
    localparam int PIN_RIGHT_A = 2;
    localparam int PIN_RIGHT_B = 3;

endpackage

// File: rtl/core/dual_quadrature_decoder_core.sv
// ----------------------------------------------------------------------------
// dual_quadrature_decoder_core
// the result word of an accepted input word is registered and shown in the next cycle
// throughput: one word per cycle while m_tready is high, set by the single state update per word
// the output register frees in the same cycle that its word is taken
// reset: synchronous active-low aresetn clears pin copy, counts and
// accumulators and empties the output register
// ----------------------------------------------------------------------------
// 4x decoding of two quadrature encoders with per-side change accumulators
// ----------------------------------------------------------------------------
module dual_quadrature_decoder_core
    import dqd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] pin_levels, [7:4] zero
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [15:0] left_position, [31:16] right_position,
                                   // [47:32] reported_change
);

    pins_t  pin_copy_reg, pin_copy_next;
    count_t left_count_reg, left_count_next;
    count_t right_count_reg, right_count_next;
    count_t left_pending_reg, left_pending_next;
    count_t right_pending_reg, right_pending_next;
    out_t   rep_reg, rep_next;
    logic   m_valid_reg;

    cmd_t   cmd;
    pins_t  pins;
    pins_t  diff;
    logic   accept;
    count_t step_left;
    count_t step_right;
    logic   left_move;
    logic   right_move;

    assign cmd      = cmd_t'(s_tuser);
    assign pins     = s_tdata[PIN_BITS-1:0];
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign diff     = pins ^ pin_copy_reg;

    always_comb begin
        pins_t  nc;
        logic   up;
        nc         = pin_copy_reg;
        up         = 1'b0;
        left_move  = 1'b0;
        right_move = 1'b0;
        priority if (diff[PIN_LEFT_A]) begin
            nc[PIN_LEFT_A] = ~pin_copy_reg[PIN_LEFT_A];
            up             = nc[PIN_LEFT_A] != nc[PIN_LEFT_B];
            left_move      = 1'b1;
        end else if (diff[PIN_LEFT_B]) begin
            nc[PIN_LEFT_B] = ~pin_copy_reg[PIN_LEFT_B];
            up             = nc[PIN_LEFT_A] == nc[PIN_LEFT_B];
            left_move      = 1'b1;
        end else if (diff[PIN_RIGHT_A]) begin
            nc[PIN_RIGHT_A] = ~pin_copy_reg[PIN_RIGHT_A];
            up              = nc[PIN_RIGHT_A] != nc[PIN_RIGHT_B];
            right_move      = 1'b1;
        end else if (diff[PIN_RIGHT_B]) begin
            nc[PIN_RIGHT_B] = ~pin_copy_reg[PIN_RIGHT_B];
            up              = nc[PIN_RIGHT_A] == nc[PIN_RIGHT_B];
            right_move      = 1'b1;
        end else begin
            nc = pin_copy_reg;
        end
        // +1, -1 or 0 in count width
        step_left  = left_move  ? (up ? count_t'(1) : '1) : '0;
        step_right = right_move ? (up ? count_t'(1) : '1) : '0;

        pin_copy_next      = pin_copy_reg;
        left_count_next    = left_count_reg;
        right_count_next   = right_count_reg;
        left_pending_next  = left_pending_reg;
        right_pending_next = right_pending_reg;
        rep_next           = '0;
        unique case (cmd)
            CMD_INIT: begin
                pin_copy_next    = pins;
                left_count_next  = '0;
                right_count_next = '0;
            end
            CMD_PIN_EVENT: begin
                pin_copy_next      = nc;
                left_count_next    = left_count_reg + step_left;
                right_count_next   = right_count_reg + step_right;
                left_pending_next  = left_pending_reg + step_left;
                right_pending_next = right_pending_reg + step_right;
            end
            CMD_REPORT_LEFT: begin
                rep_next          = OUT_BITS'(count_t'(-left_pending_reg));
                left_pending_next = '0;
            end
            CMD_REPORT_RIGHT: begin
                rep_next           = OUT_BITS'(count_t'(-right_pending_reg));
                right_pending_next = '0;
            end
            default: begin
                rep_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_copy_reg      <= '0;
            left_count_reg    <= '0;
            right_count_reg   <= '0;
            left_pending_reg  <= '0;
            right_pending_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (accept) begin
                pin_copy_reg      <= pin_copy_next;
                left_count_reg    <= left_count_next;
                right_count_reg   <= right_count_next;
                left_pending_reg  <= left_pending_next;
                right_pending_reg <= right_pending_next;
                m_valid_reg       <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rep_reg <= rep_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {rep_reg, OUT_BITS'(right_count_reg), OUT_BITS'(left_count_reg)};

    // report clears its side
    a_report_left_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd == CMD_REPORT_LEFT |=> left_pending_reg == '0)
        else $error("left accumulator not cleared by report");

    a_report_right_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd == CMD_REPORT_RIGHT |=> right_pending_reg == '0)
        else $error("right accumulator not cleared by report");

    // initialize captures pins and zeroes positions
    a_init_state: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd == CMD_INIT |=> left_count_reg == '0 && right_count_reg == '0
            && pin_copy_reg == $past(pins))
        else $error("initialize did not set state");

    // at most one pin taken per event
    a_one_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd == CMD_PIN_EVENT |=>
            $countones(pin_copy_reg ^ $past(pin_copy_reg)) <= 1)
        else $error("more than one pin taken in one event");

    // non-report words carry zero change
    a_zero_change: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (cmd == CMD_INIT || cmd == CMD_PIN_EVENT) |=> m_tdata[47:32] == '0)
        else $error("nonzero change on non-report word");

endmodule
